### sv/ssa_pkg.sv
// shared constants, types and functions for the stanley steering angle block
`timescale 1ns / 1ps
`default_nettype none
package ssa_pkg;

	localparam int CORDIC_STAGES_DEF = 16;
	localparam int TABLE_LEN = 24;
	localparam int AW = 24;
	localparam int SCW = 34;
	localparam int ATW = 52;

	localparam logic signed [17:0] ANG_PI = 18'sd12868;
	localparam logic signed [17:0] ANG_2PI = 18'sd25736;
	localparam logic signed [AW-1:0] C_PI = 24'sd205887;
	localparam logic signed [AW-1:0] C_HALF_PI = 24'sd102944;
	localparam logic signed [SCW-1:0] C_GAIN_START = 34'sd652032874;

	localparam logic [7:0] REG_GAIN = 8'd0;
	localparam logic [7:0] REG_FRONT_AXLE_OFFSET = 8'd1;

	typedef struct packed {
		logic signed [31:0] cx;
		logic signed [31:0] cy;
		logic signed [31:0] px;
		logic signed [31:0] py;
		logic signed [15:0] v;
		logic signed [17:0] th_e;
		logic neg;
	} sc_sb_t;

	typedef struct packed {
		logic signed [17:0] th_e;
		logic signed [31:0] e;
		logic zero;
	} at_sb_t;

	function automatic logic signed [AW-1:0] atan_ang(input int i);
		logic signed [AW-1:0] r;
		case (i)
			0: r = 24'sd51472;
			1: r = 24'sd30386;
			2: r = 24'sd16055;
			3: r = 24'sd8150;
			4: r = 24'sd4091;
			5: r = 24'sd2047;
			6: r = 24'sd1024;
			7: r = 24'sd512;
			8: r = 24'sd256;
			9: r = 24'sd128;
			10: r = 24'sd64;
			11: r = 24'sd32;
			12: r = 24'sd16;
			13: r = 24'sd8;
			14: r = 24'sd4;
			15: r = 24'sd2;
			16: r = 24'sd1;
			default: r = '0;
		endcase
		return r;
	endfunction

	function automatic logic signed [17:0] wrap_angle(input logic signed [17:0] a);
		logic signed [17:0] r;
		r = a;
		if (r > ANG_PI) r = r - ANG_2PI;
		if (r < -ANG_PI) r = r + ANG_2PI;
		return r;
	endfunction

endpackage
`default_nettype wire

### sv/stanley_steering_angle.sv
// stanley steering angle: cordic sin/cos chain, cross-track error, cordic atan2 chain
// one item per cycle; start to done passes through the two chains of cordic cells
// and seven arithmetic stages; busy stays low
// the receiver cannot stall: each result is shown for one cycle with done
// arst_n clears valids and resets gain to 128 and front_axle_offset to 26214
`timescale 1ns / 1ps
`default_nettype none
module stanley_steering_angle #(
	parameter int CORDIC_STAGES = ssa_pkg::CORDIC_STAGES_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_we,
	input wire logic [7:0] cfg_idx,
	input wire logic [19:0] cfg_wdata,
	input wire logic start,
	output logic busy,
	input wire logic signed [31:0] car_x,
	input wire logic signed [31:0] car_y,
	input wire logic signed [15:0] car_heading,
	input wire logic signed [15:0] car_speed,
	input wire logic signed [31:0] target_x,
	input wire logic signed [31:0] target_y,
	input wire logic signed [15:0] target_heading,
	output logic done,
	output logic signed [14:0] steer_angle,
	output logic signed [31:0] track_error
);

	localparam int N = CORDIC_STAGES;
	localparam int SCSB = $bits(ssa_pkg::sc_sb_t);
	localparam int ATSB = $bits(ssa_pkg::at_sb_t);

	logic [15:0] gain_q;
	logic [19:0] fao_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q <= 16'd128;
			fao_q <= 20'd26214;
		end else if (cfg_we) begin
			case (cfg_idx)
				ssa_pkg::REG_GAIN: gain_q <= cfg_wdata[15:0];
				ssa_pkg::REG_FRONT_AXLE_OFFSET: fao_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign busy = 1'b0;

	// stage 1: wrap headings, fold angle into the cordic range
	logic signed [17:0] yaw, pyaw;
	logic signed [ssa_pkg::AW-1:0] z0;
	logic neg0;
	ssa_pkg::sc_sb_t sb0;

	always_comb begin
		yaw = ssa_pkg::wrap_angle(18'(car_heading));
		pyaw = ssa_pkg::wrap_angle(18'(target_heading));
		z0 = ssa_pkg::AW'(yaw) <<< 4;
		neg0 = 1'b0;
		if (z0 > ssa_pkg::C_HALF_PI) begin
			z0 = z0 - ssa_pkg::C_PI;
			neg0 = 1'b1;
		end else if (z0 < -ssa_pkg::C_HALF_PI) begin
			z0 = z0 + ssa_pkg::C_PI;
			neg0 = 1'b1;
		end
		sb0.cx = car_x;
		sb0.cy = car_y;
		sb0.px = target_x;
		sb0.py = target_y;
		sb0.v = car_speed;
		sb0.th_e = ssa_pkg::wrap_angle(pyaw - yaw);
		sb0.neg = neg0;
	end

	logic sc_v [0:N];
	logic signed [ssa_pkg::SCW-1:0] sc_x [0:N];
	logic signed [ssa_pkg::SCW-1:0] sc_y [0:N];
	logic signed [ssa_pkg::AW-1:0] sc_z [0:N];
	logic [SCSB-1:0] sc_sb [0:N];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sc_v[0] <= 1'b0;
		end else begin
			sc_v[0] <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		sc_x[0] <= ssa_pkg::C_GAIN_START;
		sc_y[0] <= '0;
		sc_z[0] <= z0;
		sc_sb[0] <= sb0;
	end

	for (genvar k = 0; k < N; k++) begin : g_sc
		ssa_cordic_cell #(
			.XW(ssa_pkg::SCW), .SBW(SCSB), .STAGE(k), .VECTOR(1'b0)
		) u_cell (
			.clk(clk), .arst_n(arst_n),
			.in_valid(sc_v[k]), .in_x(sc_x[k]), .in_y(sc_y[k]),
			.in_z(sc_z[k]), .in_sb(sc_sb[k]),
			.out_valid(sc_v[k+1]), .out_x(sc_x[k+1]), .out_y(sc_y[k+1]),
			.out_z(sc_z[k+1]), .out_sb(sc_sb[k+1])
		);
	end

	// stage 2: sign fix and front axle offset products
	ssa_pkg::sc_sb_t sbn;
	logic signed [ssa_pkg::SCW-1:0] s_n, c_n;
	assign sbn = sc_sb[N];
	assign s_n = sbn.neg ? -sc_y[N] : sc_y[N];
	assign c_n = sbn.neg ? -sc_x[N] : sc_x[N];

	logic v_s2, v_s3, v_s4, v_s5, v_s6;
	ssa_pkg::sc_sb_t sb_s2, sb_s3, sb_s4;
	logic signed [ssa_pkg::SCW-1:0] s_s2, c_s2, s_s3, c_s3;
	logic signed [54:0] pc_s2, ps_s2;
	logic signed [36:0] dx_s3, dy_s3;
	logic signed [70:0] mx_s4, my_s4;
	logic signed [31:0] e_s5;
	logic signed [15:0] v_spd_s5, v_spd_s6;
	logic signed [17:0] th_s5, th_s6;
	logic signed [48:0] gy_s6;
	logic signed [31:0] e_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			v_s2 <= sc_v[N];
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
		end
	end

	logic signed [35:0] fx, fy;
	logic signed [71:0] t5;
	logic signed [55:0] e_w;
	logic signed [31:0] e_sat;

	always_comb begin
		fx = 36'(sb_s2.cx) + 36'(pc_s2 >>> 30);
		fy = 36'(sb_s2.cy) + 36'(ps_s2 >>> 30);
		t5 = 72'(mx_s4 >>> 14) - 72'(my_s4 >>> 14);
		e_w = 56'(t5 >>> 16);
		if (e_w > 56'sd2147483647) e_sat = 32'sh7fffffff;
		else if (e_w < -56'sd2147483648) e_sat = 32'sh80000000;
		else e_sat = e_w[31:0];
	end

	always_ff @(posedge clk) begin
		sb_s2 <= sbn;
		s_s2 <= s_n;
		c_s2 <= c_n;
		pc_s2 <= $signed({1'b0, fao_q}) * c_n;
		ps_s2 <= $signed({1'b0, fao_q}) * s_n;
		sb_s3 <= sb_s2;
		s_s3 <= s_s2;
		c_s3 <= c_s2;
		dx_s3 <= 37'(fx) - 37'(sb_s2.px);
		dy_s3 <= 37'(fy) - 37'(sb_s2.py);
		sb_s4 <= sb_s3;
		mx_s4 <= dx_s3 * s_s3;
		my_s4 <= dy_s3 * c_s3;
		e_s5 <= e_sat;
		v_spd_s5 <= sb_s4.v;
		th_s5 <= sb_s4.th_e;
		gy_s6 <= $signed({1'b0, gain_q}) * e_s5;
		e_s6 <= e_s5;
		v_spd_s6 <= v_spd_s5;
		th_s6 <= th_s5;
	end

	// atan2 setup: half-plane fold and zero detect
	logic signed [ssa_pkg::ATW-1:0] ax0, ay0;
	logic signed [ssa_pkg::AW-1:0] az0;
	ssa_pkg::at_sb_t asb0;

	always_comb begin
		ax0 = ssa_pkg::ATW'(v_spd_s6) <<< 16;
		ay0 = ssa_pkg::ATW'(gy_s6);
		az0 = '0;
		asb0.th_e = th_s6;
		asb0.e = e_s6;
		asb0.zero = (ax0 == 0) && (ay0 == 0);
		if (ax0 < 0) begin
			az0 = (ay0 >= 0) ? ssa_pkg::C_PI : -ssa_pkg::C_PI;
			ax0 = -ax0;
			ay0 = -ay0;
		end
	end

	logic at_v [0:N];
	logic signed [ssa_pkg::ATW-1:0] at_x [0:N];
	logic signed [ssa_pkg::ATW-1:0] at_y [0:N];
	logic signed [ssa_pkg::AW-1:0] at_z [0:N];
	logic [ATSB-1:0] at_sb [0:N];

	assign at_v[0] = v_s6;
	assign at_x[0] = ax0;
	assign at_y[0] = ay0;
	assign at_z[0] = az0;
	assign at_sb[0] = asb0;

	for (genvar k = 0; k < N; k++) begin : g_at
		ssa_cordic_cell #(
			.XW(ssa_pkg::ATW), .SBW(ATSB), .STAGE(k), .VECTOR(1'b1)
		) u_cell (
			.clk(clk), .arst_n(arst_n),
			.in_valid(at_v[k]), .in_x(at_x[k]), .in_y(at_y[k]),
			.in_z(at_z[k]), .in_sb(at_sb[k]),
			.out_valid(at_v[k+1]), .out_x(at_x[k+1]), .out_y(at_y[k+1]),
			.out_z(at_z[k+1]), .out_sb(at_sb[k+1])
		);
	end

	// output stage: round, add heading error, wrap
	ssa_pkg::at_sb_t asbn;
	logic signed [ssa_pkg::AW-1:0] zr;
	logic signed [17:0] th_d, delta;

	always_comb begin
		asbn = at_sb[N];
		zr = (at_z[N] + ssa_pkg::AW'(8)) >>> 4;
		th_d = asbn.zero ? 18'sd0 : zr[17:0];
		delta = ssa_pkg::wrap_angle(asbn.th_e + th_d);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= at_v[N];
		end
	end

	always_ff @(posedge clk) begin
		steer_angle <= delta[14:0];
		track_error <= asbn.e;
	end

	// at_x and at_y of the last cell are not needed beyond the angle
	logic unused_ok;
	assign unused_ok = ^{at_x[N], at_y[N], sc_z[N]};

endmodule
`default_nettype wire

### sv/ssa_cordic_cell.sv
// one cordic micro-rotation cell, rotation or vectoring mode, with sideband
`timescale 1ns / 1ps
`default_nettype none
module ssa_cordic_cell #(
	parameter int XW = 34,
	parameter int SBW = 1,
	parameter int STAGE = 0,
	parameter bit VECTOR = 1'b0
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	input wire logic signed [XW-1:0] in_x,
	input wire logic signed [XW-1:0] in_y,
	input wire logic signed [ssa_pkg::AW-1:0] in_z,
	input wire logic [SBW-1:0] in_sb,
	output logic out_valid,
	output logic signed [XW-1:0] out_x,
	output logic signed [XW-1:0] out_y,
	output logic signed [ssa_pkg::AW-1:0] out_z,
	output logic [SBW-1:0] out_sb
);

	logic pos;
	logic signed [XW-1:0] xs, ys, x_n, y_n;
	logic signed [ssa_pkg::AW-1:0] ang, z_n;

	always_comb begin
		pos = VECTOR ? !(in_y > 0) : (in_z >= 0);
		xs = in_x >>> STAGE;
		ys = in_y >>> STAGE;
		ang = ssa_pkg::atan_ang(STAGE);
		x_n = pos ? in_x - ys : in_x + ys;
		y_n = pos ? in_y + xs : in_y - xs;
		z_n = pos ? in_z - ang : in_z + ang;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else begin
			out_valid <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		out_x <= x_n;
		out_y <= y_n;
		out_z <= z_n;
		out_sb <= in_sb;
	end

endmodule
`default_nettype wire

### test/tb_stanley_steering_angle.sv
// testbench for stanley_steering_angle: queued directed and random poses, own fixed-point prediction
`timescale 1ns / 1ps
`default_nettype none
module tb_stanley_steering_angle;

	localparam int STAGES = ssa_pkg::CORDIC_STAGES_DEF;
	localparam int LATENCY = 2 * STAGES + 7;
	localparam int DOG_LIMIT = 4000;
	localparam longint PI_A = 12868;
	localparam longint TWO_PI_A = 25736;
	localparam longint PI_C = 205887;
	localparam longint HALF_PI_C = 102944;
	localparam logic [7:0] REG_UNUSED = 8'd2;

	typedef struct {
		logic signed [31:0] cx, cy, px, py;
		logic signed [15:0] ch, ph, v;
	} pose_t;

	typedef struct {
		logic signed [14:0] steer;
		logic signed [31:0] err;
	} steer_t;

	logic clk = 0, arst_n = 0;
	logic cfg_we = 0;
	logic [7:0] cfg_idx = '0;
	logic [19:0] cfg_wdata = '0;
	logic start = 0;
	logic signed [31:0] car_x = 0, car_y = 0, target_x = 0, target_y = 0;
	logic signed [15:0] car_heading = 0, car_speed = 0, target_heading = 0;
	wire busy, done;
	wire signed [14:0] steer_angle;
	wire signed [31:0] track_error;

	stanley_steering_angle DUT (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_idx(cfg_idx),
		.cfg_wdata(cfg_wdata), .start(start), .busy(busy),
		.car_x(car_x), .car_y(car_y), .car_heading(car_heading), .car_speed(car_speed),
		.target_x(target_x), .target_y(target_y), .target_heading(target_heading),
		.done(done), .steer_angle(steer_angle), .track_error(track_error)
	);

	always #5 clk = ~clk;

	longint gain_q = 128, offset_q = 26214;
	pose_t poses[$];
	steer_t expected_steer[$];
	int queued = 0, transfers = 0, errors = 0, send_idle = 0, quiet = 0;
	logic took = 0;

	function automatic longint angle_tab(int i);
		longint t[17] = '{51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
			256, 128, 64, 32, 16, 8, 4, 2, 1};
		return (i < 17) ? t[i] : 0;
	endfunction

	function automatic longint wrap(longint a);
		if (a > PI_A) a -= TWO_PI_A;
		if (a < -PI_A) a += TWO_PI_A;
		return a;
	endfunction

	function automatic longint arctan2(longint y, longint x);
		longint z = 0, t;
		if (x == 0 && y == 0) return 0;
		if (x < 0) begin
			z = (y >= 0) ? PI_C : -PI_C;
			x = -x;
			y = -y;
		end
		for (int i = 0; i < STAGES; i++) begin
			if (y > 0) begin
				t = x + (y >>> i); y = y - (x >>> i); x = t; z += angle_tab(i);
			end else begin
				t = x - (y >>> i); y = y + (x >>> i); x = t; z -= angle_tab(i);
			end
		end
		return (z + 8) >>> 4;
	endfunction

	function automatic steer_t steering(pose_t p);
		longint yaw, z, x, y, t, s, c, fx, fy, e, th_e;
		logic neg;
		steer_t r;
		yaw = wrap(longint'(p.ch));
		z = yaw * 16;
		x = 652032874;
		y = 0;
		neg = 0;
		if (z > HALF_PI_C) begin z -= PI_C; neg = 1; end
		else if (z < -HALF_PI_C) begin z += PI_C; neg = 1; end
		for (int i = 0; i < STAGES; i++) begin
			if (z >= 0) begin
				t = x - (y >>> i); y = y + (x >>> i); x = t; z -= angle_tab(i);
			end else begin
				t = x + (y >>> i); y = y - (x >>> i); x = t; z += angle_tab(i);
			end
		end
		s = neg ? -y : y;
		c = neg ? -x : x;
		fx = longint'(p.cx) + ((offset_q * c) >>> 30);
		fy = longint'(p.cy) + ((offset_q * s) >>> 30);
		e = ((((fx - p.px) * s) >>> 14) - (((fy - p.py) * c) >>> 14)) >>> 16;
		if (e > 64'sd2147483647) e = 64'sd2147483647;
		if (e < -64'sd2147483648) e = -64'sd2147483648;
		th_e = wrap(wrap(longint'(p.ph)) - yaw);
		r.steer = 15'(wrap(th_e + arctan2(gain_q * e, longint'(p.v) * 65536)));
		r.err = 32'(e);
		return r;
	endfunction

	// driver
	always @(negedge clk) begin
		pose_t p;
		if (arst_n && (!start || took)) begin
			if (poses.size() > 0 && $urandom_range(99) >= send_idle) begin
				p = poses.pop_front();
				car_x <= p.cx; car_y <= p.cy; car_heading <= p.ch; car_speed <= p.v;
				target_x <= p.px; target_y <= p.py; target_heading <= p.ph;
				start <= 1;
			end else
				start <= 0;
		end
	end

	// monitor
	always @(posedge clk) begin
		pose_t p;
		steer_t w;
		took <= start && !busy;
		if (start && !busy) begin
			p.cx = car_x; p.cy = car_y; p.ch = car_heading; p.v = car_speed;
			p.px = target_x; p.py = target_y; p.ph = target_heading;
			expected_steer.push_back(steering(p));
			transfers++;
		end
		if (done) begin
			if (expected_steer.size() == 0) begin
				$display("%0t unexpected result steer=%0d err=%0d", $time,
					steer_angle, track_error);
				errors++;
			end else begin
				w = expected_steer.pop_front();
				if (steer_angle !== w.steer) begin
					$display("%0t steer_angle expected %0d actual %0d", $time, w.steer,
						steer_angle);
					errors++;
				end
				if (track_error !== w.err) begin
					$display("%0t track_error expected %0d actual %0d", $time, w.err,
						track_error);
					errors++;
				end
			end
		end
		quiet = ((start && !busy) || done || cfg_we || !arst_n) ? 0 : quiet + 1;
		if (quiet >= DOG_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	task automatic write_reg(logic [7:0] idx, logic [19:0] val);
		@(negedge clk);
		cfg_we <= 1; cfg_idx <= idx; cfg_wdata <= val;
		@(negedge clk);
		cfg_we <= 0;
		if (idx == ssa_pkg::REG_GAIN) gain_q = longint'(val[15:0]);
		else if (idx == ssa_pkg::REG_FRONT_AXLE_OFFSET) offset_q = longint'(val);
	endtask

	task automatic add_pose(logic signed [31:0] cx, cy, px, py,
		logic signed [15:0] ch, ph, v);
		pose_t p;
		p.cx = cx; p.cy = cy; p.px = px; p.py = py; p.ch = ch; p.ph = ph; p.v = v;
		poses.push_back(p);
		queued++;
	endtask

	function automatic logic signed [31:0] rand_pos();
		case ($urandom_range(3))
			0: return $urandom;
			1: return $signed($urandom_range(2097152)) - 32'sd1048576;
			2: return $signed($urandom_range(131072)) - 32'sd65536;
			default: return $urandom_range(1) ? 32'h7fffffff : 32'h80000000;
		endcase
	endfunction

	function automatic logic signed [15:0] rand_heading();
		return $urandom_range(9) == 0 ? ($urandom_range(1) ? 16'sd25736 : -16'sd25736)
			: 16'($signed($urandom_range(51472)) - 25736);
	endfunction

	task automatic random_poses(int n);
		logic signed [31:0] cx, cy;
		repeat (n) begin
			cx = rand_pos();
			cy = rand_pos();
			if ($urandom_range(3) != 0)
				add_pose(cx, cy, cx + $signed($urandom_range(1 << 20)) - (1 << 19),
					cy + $signed($urandom_range(1 << 20)) - (1 << 19), rand_heading(),
					rand_heading(), $urandom_range(1) ? 16'($urandom) :
					16'($signed($urandom_range(2048)) - 1024));
			else
				add_pose(cx, cy, rand_pos(), rand_pos(), rand_heading(), rand_heading(),
					16'($urandom));
		end
	endtask

	task automatic drain();
		while (transfers != queued || expected_steer.size() != 0) @(posedge clk);
		repeat (LATENCY + 20) @(posedge clk);
	endtask

	initial begin
		automatic int phase_idle[6] = '{28, 28, 82, 82, 0, 0};
		automatic logic [19:0] gains[6] = '{128, 0, 65535, 256,
			20'($urandom_range(65535)), 1};
		automatic logic [19:0] offs[6] = '{26214, 0, 1048575, 65536,
			20'($urandom_range(1048575)), 26214};
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1;
		// directed: zero case, speed signs, heading and position extremes
		add_pose(0, 0, 0, 0, 0, 0, 0);
		add_pose(0, 0, 0, 0, 0, 0, -16'sd256);
		add_pose(0, 0, 0, 0, 0, 0, 16'sd32767);
		add_pose(0, 0, 0, 0, 0, 0, -16'sd32768);
		add_pose(0, 0, 0, 0, 16'sd25736, -16'sd25736, 256);
		add_pose(0, 0, 0, 0, -16'sd25736, 16'sd25736, 256);
		add_pose(0, 0, 0, 0, 16'sd12868, -16'sd12868, 256);
		add_pose(0, 0, 0, 0, 16'sd12869, -16'sd12869, 256);
		add_pose(0, 0, 0, 0, 16'sd6434, 0, -16'sd256);
		add_pose(32'h7fffffff, 32'h7fffffff, 32'h80000000, 32'h80000000, 16'sd3217, 0, 1);
		add_pose(32'h80000000, 32'h80000000, 32'h7fffffff, 32'h7fffffff, -16'sd3217,
			0, -1);
		add_pose(32'h7fffffff, 32'h80000000, 32'h80000000, 32'h7fffffff, 16'sd9651,
			16'sd25736, 0);
		add_pose(65536, 0, 0, 65536, 0, 16'sd1000, 256);
		add_pose(0, 0, 65536, 0, 16'sd6434, -16'sd1000, 0);
		add_pose(-1, -1, 1, 1, -16'sd6434, 16'sd12868, -16'sd32768);
		drain();
		for (int ph = 0; ph < 6; ph++) begin
			write_reg(ssa_pkg::REG_GAIN, gains[ph]);
			write_reg(ssa_pkg::REG_FRONT_AXLE_OFFSET, offs[ph]);
			if (ph == 5) write_reg(REG_UNUSED, 20'hfffff);
			send_idle = phase_idle[ph];
			random_poses(250);
			drain();
		end
		if (errors == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end
endmodule
`default_nettype wire
